// File: design/i2cow_pkg.sv
package i2cow_pkg;

  // command bytes
  localparam logic [7:0] CMD_DEV_RESET  = 8'hF0;
  localparam logic [7:0] CMD_SET_PTR    = 8'hE1;
  localparam logic [7:0] CMD_WR_CONFIG  = 8'hD2;
  localparam logic [7:0] CMD_WIRE_RESET = 8'hB4;
  localparam logic [7:0] CMD_SINGLE_BIT = 8'h87;
  localparam logic [7:0] CMD_WRITE_BYTE = 8'hA5;
  localparam logic [7:0] CMD_READ_BYTE  = 8'h96;
  localparam logic [7:0] CMD_TRIPLET    = 8'h78;

  // read pointer codes
  localparam logic [7:0] REG_STATUS = 8'hF0;
  localparam logic [7:0] REG_DATA   = 8'hE1;
  localparam logic [7:0] REG_CONFIG = 8'hC3;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [3:0] NIBBLE_ONES   = 4'hF;

  // awaited argument kinds
  localparam logic [1:0] ARG_NONE   = 2'd0;
  localparam logic [1:0] ARG_PTR    = 2'd1;
  localparam logic [1:0] ARG_CONFIG = 2'd2;
  localparam logic [1:0] ARG_WBYTE  = 2'd3;

  // 1-wire actions
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_UNK_CMD  = 2'd1;
  localparam logic [1:0] ERR_CFG_REJ  = 2'd2;
  localparam logic [1:0] ERR_UNK_REG  = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] wr_byte;
    logic       last_in_write;
    logic       presence_seen;
    logic [7:0] wire_read_byte;
  } req_t;

  // status only ever carries the reset and presence bits
  typedef struct packed {
    logic [7:0] read_select;
    logic [3:0] config_bits;
    logic       st_rst;
    logic       st_ppd;
    logic [7:0] data_latch;
    logic [1:0] pending_arg;
  } bridge_state_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic [1:0] wire_op;
    logic [7:0] wire_byte;
    logic [1:0] cmd_error;
  } result_t;

  function automatic logic [7:0] status_byte(input logic rst, input logic ppd);
    status_byte = {3'b000, rst, 2'b00, ppd, 1'b0};
  endfunction

endpackage

// File: design/i2cow_decode.sv
module i2cow_decode (
  input  i2cow_pkg::req_t          req,
  input  i2cow_pkg::bridge_state_t cur,
  input  logic                     device_attached,
  output i2cow_pkg::bridge_state_t nxt,
  output i2cow_pkg::result_t       res
);
  import i2cow_pkg::*;

  logic cfg_ok;

  assign cfg_ok = ((req.wr_byte[7:4] ^ NIBBLE_ONES) == req.wr_byte[3:0]);

  always_comb begin
    nxt = cur;
    res = '0;
    if (req.req_type) begin
      // read abandons any awaited argument
      nxt.pending_arg = ARG_NONE;
      case (cur.read_select)
        REG_STATUS: res.rd_data = status_byte(cur.st_rst, cur.st_ppd);
        REG_DATA:   res.rd_data = cur.data_latch;
        REG_CONFIG: res.rd_data = {4'h0, cur.config_bits};
        default: begin
          res.rd_data   = BYTE_ALL_ONES;
          res.cmd_error = ERR_UNK_REG;
        end
      endcase
    end else if (cur.pending_arg != ARG_NONE) begin
      nxt.pending_arg = ARG_NONE;
      case (cur.pending_arg)
        ARG_PTR: nxt.read_select = req.wr_byte;
        ARG_CONFIG: begin
          if (cfg_ok) begin
            nxt.config_bits = req.wr_byte[3:0];
            nxt.st_rst      = 1'b0;
          end else begin
            res.cmd_error = ERR_CFG_REJ;
          end
        end
        default: begin
          res.wire_op   = OP_WRITE;
          res.wire_byte = req.wr_byte;
        end
      endcase
    end else begin
      case (req.wr_byte)
        CMD_DEV_RESET: begin
          nxt.read_select = REG_STATUS;
          nxt.config_bits = 4'h0;
          nxt.st_rst      = 1'b1;
          nxt.st_ppd      = 1'b0;
        end
        CMD_SET_PTR:    if (!req.last_in_write) nxt.pending_arg = ARG_PTR;
        CMD_WR_CONFIG:  if (!req.last_in_write) nxt.pending_arg = ARG_CONFIG;
        CMD_WRITE_BYTE: if (!req.last_in_write) nxt.pending_arg = ARG_WBYTE;
        CMD_WIRE_RESET: begin
          res.wire_op = OP_RESET;
          nxt.st_ppd  = device_attached & req.presence_seen;
        end
        CMD_READ_BYTE: begin
          res.wire_op    = OP_READ;
          nxt.data_latch = device_attached ? req.wire_read_byte : BYTE_ALL_ONES;
        end
        CMD_SINGLE_BIT, CMD_TRIPLET: ;
        default: res.cmd_error = ERR_UNK_CMD;
      endcase
    end
  end

endmodule

// File: design/i2c_onewire_bridge_model.sv
// a result is registered and shown in the cycle after its transfer is accepted
// throughput: one transfer per cycle; only a stalled result held in the
//   output register stops the input side
// reset (rst_n low, synchronous): read pointer at status, config, status and
//   pending argument cleared, data latch all ones, no slave attached
module i2c_onewire_bridge_model (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_wr_byte,
  input  logic       in_last_in_write,
  input  logic       in_presence_seen,
  input  logic [7:0] in_wire_read_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rd_data,
  output logic [1:0] out_wire_op,
  output logic [7:0] out_wire_byte,
  output logic [1:0] out_cmd_error
);
  import i2cow_pkg::*;

  logic          device_attached_r;
  bridge_state_t state_r;
  bridge_state_t state_nxt;
  result_t       res_nxt;
  result_t       res_r;
  logic          out_valid_r;
  req_t          req;
  logic          in_take;

  // input side waits only while a result sits unclaimed in the output register
  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  assign req = '{req_type:       in_req_type,
                 wr_byte:        in_wr_byte,
                 last_in_write:  in_last_in_write,
                 presence_seen:  in_presence_seen,
                 wire_read_byte: in_wire_read_byte};

  // command decode, register select and bridge state update
  i2cow_decode u_decode (
    .req             (req),
    .cur             (state_r),
    .device_attached (device_attached_r),
    .nxt             (state_nxt),
    .res             (res_nxt)
  );

  // slave-attached flag; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_attached_r <= 1'b0;
    end else if (cfg_wr_en) begin
      device_attached_r <= cfg_wr_data;
    end
  end

  // bridge state commits on every accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{read_select: REG_STATUS,
                   config_bits: 4'h0,
                   st_rst:      1'b0,
                   st_ppd:      1'b0,
                   data_latch:  BYTE_ALL_ONES,
                   pending_arg: ARG_NONE};
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // output register: loads on accept, empties when the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rd_data   = res_r.rd_data;
  assign out_wire_op   = res_r.wire_op;
  assign out_wire_byte = res_r.wire_byte;
  assign out_cmd_error = res_r.cmd_error;

endmodule
